>>> hw/rtl/bitmap_run_allocator_top_macros.svh
// Assertion macros used by the allocator top level.
`ifndef BITMAP_RUN_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset
`define BRA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset
`define BRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/bra_pkg.sv
// Types and constants of the bitmap run allocator.
`timescale 1ns / 1ps
`default_nettype none

package bra_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int OP_W   = 3;
    localparam int IDX_W  = 10;
    localparam int LEN_W  = 11;
    localparam int CFG_W  = 8;

    // Reset value of the bytes-in-use register
    localparam logic [CFG_W-1:0] CFG_BYTES_RST = 8'd128;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd0;
    localparam logic [OP_W-1:0] OP_TEST      = 3'd1;
    localparam logic [OP_W-1:0] OP_SET       = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd3;
    localparam logic [OP_W-1:0] OP_SCAN      = 3'd4;

    // Controller states, one-hot
    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_MOD   = 5'b00100,
        S_SCAN  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/bitmap_run_allocator_top.sv
// Top level of the first-fit bitmap run allocator.
`timescale 1ns / 1ps
`default_nettype none

// First-fit bitmap allocator. The used/free map lives in one MAP_BYTES x 8
// synchronous RAM, one bit per unit (1 = used). One request is handled at a
// time and each gives exactly one result word. Test, set and clear go
// through read, modify/write and result; a bit beyond the map skips the
// read. A scan reads one map byte per cycle through the RAM read port and
// checks its eight bits when the registered read data returns, covering
// up to min(bytes_in_use, MAP_BYTES) bytes and stopping early on the first
// run that fits. Clear-all sweeps the RAM one byte per cycle. After reset
// the same sweep runs with in_ready low; the config port is always ready.
// A finished result sits in an output register, so the next request can
// be accepted while it waits for out_ready.
`include "bitmap_run_allocator_top_macros.svh"

module bitmap_run_allocator_top #(
    parameter int MAP_BYTES = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [bra_pkg::OP_W-1:0]        opcode,
    input  logic [bra_pkg::IDX_W-1:0]       bit_index,
    input  logic [bra_pkg::LEN_W-1:0]       run_length,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            found,
    output logic [bra_pkg::IDX_W-1:0]       run_start,
    output logic                            bit_value,
    // config channel (bytes_in_use)
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bra_pkg::CFG_W-1:0]       cfg_data
);

    localparam int AW  = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int BW  = bra_pkg::BYTE_W;
    localparam int CW  = bra_pkg::CFG_W;
    localparam int LW  = bra_pkg::LEN_W;
    localparam int IW  = bra_pkg::IDX_W;

    // control state
    bra_pkg::state_t          state_reg, state_next;
    logic [AW-1:0]            clr_ptr_reg, clr_ptr_next;
    logic                     clr_res_reg, clr_res_next;
    logic [CW-1:0]            rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]            proc_ptr_reg, proc_ptr_next;
    logic                     rv_reg, rv_next;
    logic                     out_valid_reg, out_valid_next;
    logic [CW-1:0]            cfg_bytes_reg, cfg_bytes_next;

    // payload
    logic [bra_pkg::OP_W-1:0] op_reg, op_next;
    logic [IW-1:0]            idx_reg, idx_next;
    logic [LW-1:0]            len_reg, len_next;
    logic [LW-1:0]            streak_reg, streak_next;
    logic                     res_found_reg, res_found_next;
    logic [IW-1:0]            res_start_reg, res_start_next;
    logic                     res_bit_reg, res_bit_next;
    logic                     out_found_reg, out_found_next;
    logic [IW-1:0]            out_start_reg, out_start_next;
    logic                     out_bit_reg, out_bit_next;

    // map RAM ports
    logic [BW-1:0]            usage_map [MAP_BYTES];
    logic                     mem_we, mem_re;
    logic [AW-1:0]            mem_waddr, mem_raddr;
    logic [BW-1:0]            mem_wdata, mem_rdata;

    // misc
    logic [CW-1:0]            nbytes;
    logic                     in_map_req, in_map_cur;
    logic [BW-1:0]            bit_mask;
    logic                     out_free;
    logic [LW-1:0]            scan_streak;
    logic                     scan_hit;
    logic [LW-1:0]            scan_start;
    logic [LW-1:0]            scan_base;

    assign in_ready  = (state_reg == bra_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign found     = out_found_reg;
    assign run_start = out_start_reg;
    assign bit_value = out_bit_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // bytes covered by a scan, clipped to the map size
    assign nbytes = (32'(cfg_bytes_reg) > MAP_BYTES) ? CW'(MAP_BYTES) : cfg_bytes_reg;

    // byte of the addressed bit inside the map
    assign in_map_req = (32'(bit_index[IW-1:3]) < MAP_BYTES);
    assign in_map_cur = (32'(idx_reg[IW-1:3]) < MAP_BYTES);
    assign bit_mask   = BW'(1) << idx_reg[2:0];

    // run search over the eight bits of the byte the RAM returns this cycle
    always_comb
    begin
        scan_streak = streak_reg;
        scan_hit    = 1'b0;
        scan_start  = '0;
        scan_base   = {proc_ptr_reg, 3'b000};
        for (int b = 0; b < BW; b++)
        begin
            if (mem_rdata[b])
                scan_streak = '0;
            else
                scan_streak = scan_streak + LW'(1);
            if (!scan_hit && (scan_streak == len_reg))
            begin
                scan_hit   = 1'b1;
                scan_start = scan_base + LW'(b) + LW'(1) - len_reg;
            end
        end
    end

    // controller
    always_comb
    begin
        state_next     = state_reg;
        clr_ptr_next   = clr_ptr_reg;
        clr_res_next   = clr_res_reg;
        rd_ptr_next    = rd_ptr_reg;
        proc_ptr_next  = proc_ptr_reg;
        rv_next        = 1'b0;
        out_valid_next = out_valid_reg;
        cfg_bytes_next = cfg_bytes_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        streak_next    = streak_reg;
        res_found_next = res_found_reg;
        res_start_next = res_start_reg;
        res_bit_next   = res_bit_reg;
        out_found_next = out_found_reg;
        out_start_next = out_start_reg;
        out_bit_next   = out_bit_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = '0;
        mem_raddr      = '0;
        mem_wdata      = '0;

        // config write
        if (cfg_valid)
            cfg_bytes_next = cfg_data;

        // result word taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            bra_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_ptr_reg;
                if (clr_ptr_reg == AW'(MAP_BYTES - 1))
                begin
                    clr_ptr_next = '0;
                    clr_res_next = 1'b0;
                    state_next   = clr_res_reg ? bra_pkg::S_DONE : bra_pkg::S_IDLE;
                end
                else
                begin
                    clr_ptr_next = clr_ptr_reg + AW'(1);
                end
            end

            bra_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next        = opcode;
                    idx_next       = bit_index;
                    len_next       = run_length;
                    res_found_next = 1'b0;
                    res_start_next = '0;
                    res_bit_next   = 1'b0;
                    if (opcode == bra_pkg::OP_CLEAR_ALL)
                    begin
                        clr_res_next = 1'b1;
                        clr_ptr_next = '0;
                        state_next   = bra_pkg::S_CLEAR;
                    end
                    else if (opcode inside {bra_pkg::OP_TEST, bra_pkg::OP_SET,
                                            bra_pkg::OP_CLEAR})
                    begin
                        // bit beyond the map: test reads 0, set/clear do nothing
                        if (in_map_req)
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = AW'(bit_index[IW-1:3]);
                            state_next = bra_pkg::S_MOD;
                        end
                        else
                        begin
                            state_next = bra_pkg::S_DONE;
                        end
                    end
                    else if (opcode == bra_pkg::OP_SCAN)
                    begin
                        // zero length or empty window: not found
                        if ((run_length == '0) || (nbytes == '0))
                        begin
                            state_next = bra_pkg::S_DONE;
                        end
                        else
                        begin
                            rd_ptr_next   = '0;
                            proc_ptr_next = '0;
                            streak_next   = '0;
                            state_next    = bra_pkg::S_SCAN;
                        end
                    end
                    else
                    begin
                        state_next = bra_pkg::S_DONE;
                    end
                end
            end

            bra_pkg::S_MOD:
            begin
                case (op_reg)
                    bra_pkg::OP_TEST:
                        res_bit_next = mem_rdata[idx_reg[2:0]];
                    bra_pkg::OP_SET:
                    begin
                        mem_we    = in_map_cur;
                        mem_waddr = AW'(idx_reg[IW-1:3]);
                        mem_wdata = mem_rdata | bit_mask;
                    end
                    bra_pkg::OP_CLEAR:
                    begin
                        mem_we    = in_map_cur;
                        mem_waddr = AW'(idx_reg[IW-1:3]);
                        mem_wdata = mem_rdata & ~bit_mask;
                    end
                    default:
                        res_bit_next = 1'b0;
                endcase
                state_next = bra_pkg::S_DONE;
            end

            bra_pkg::S_SCAN:
            begin
                // stream reads, one byte per cycle
                if (rd_ptr_reg < nbytes)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = AW'(rd_ptr_reg);
                    rd_ptr_next = rd_ptr_reg + CW'(1);
                    rv_next     = 1'b1;
                end
                // check the byte that came back
                if (rv_reg)
                begin
                    proc_ptr_next = proc_ptr_reg + CW'(1);
                    streak_next   = scan_streak;
                    if (scan_hit)
                    begin
                        res_found_next = 1'b1;
                        res_start_next = scan_start[IW-1:0];
                        rv_next        = 1'b0;
                        state_next     = bra_pkg::S_DONE;
                    end
                    else if (proc_ptr_reg == (nbytes - CW'(1)))
                    begin
                        rv_next    = 1'b0;
                        state_next = bra_pkg::S_DONE;
                    end
                end
            end

            bra_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_start_next = res_start_reg;
                    out_bit_next   = res_bit_reg;
                    state_next     = bra_pkg::S_IDLE;
                end
            end

            default:
                state_next = bra_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bra_pkg::S_CLEAR;
            clr_ptr_reg   <= '0;
            clr_res_reg   <= 1'b0;
            rd_ptr_reg    <= '0;
            proc_ptr_reg  <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_bytes_reg <= bra_pkg::CFG_BYTES_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            clr_res_reg   <= clr_res_next;
            rd_ptr_reg    <= rd_ptr_next;
            proc_ptr_reg  <= proc_ptr_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
            cfg_bytes_reg <= cfg_bytes_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        len_reg       <= len_next;
        streak_reg    <= streak_next;
        res_found_reg <= res_found_next;
        res_start_reg <= res_start_next;
        res_bit_reg   <= res_bit_next;
        out_found_reg <= out_found_next;
        out_start_reg <= out_start_next;
        out_bit_reg   <= out_bit_next;
    end

    // map RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            usage_map[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata <= usage_map[mem_raddr];
    end

    // checks
    `BRA_ASSERT_NOW(a_no_write_in_scan, state_reg == bra_pkg::S_SCAN, !mem_we,
        "map written during a scan")
    `BRA_ASSERT_NOW(a_rw_apart, mem_we && mem_re, mem_waddr != mem_raddr,
        "map read and written at the same byte")
    `BRA_ASSERT_NOW(a_scan_ptrs, state_reg == bra_pkg::S_SCAN,
        (rd_ptr_reg <= nbytes) && (proc_ptr_reg < nbytes) && (proc_ptr_reg <= rd_ptr_reg),
        "scan pointers outside the window")
    `BRA_ASSERT_NEXT(a_done_loads, (state_reg == bra_pkg::S_DONE) && out_free,
        out_valid && in_ready, "result not presented after completion")

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the bitmap run allocator: directed and paced random traffic.
`timescale 1ns / 1ps

module tb;

    localparam int OP_W          = bra_pkg::OP_W;
    localparam int IDX_W         = bra_pkg::IDX_W;
    localparam int LEN_W         = bra_pkg::LEN_W;
    localparam int CFG_W         = bra_pkg::CFG_W;
    localparam int MAP_BYTES     = 128;
    localparam int MAP_BITS      = MAP_BYTES * 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = MAP_BYTES + 12;
    localparam int REPORT_MAX    = 10;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int PHASES        = 12;

    // Opcodes the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] run_start;
        logic             bit_value;
    } alloc_result_t;

    logic             clk;
    logic             rst_n      = 1'b0;
    logic             in_valid   = 1'b0;
    logic             in_ready;
    logic [OP_W-1:0]  opcode     = bra_pkg::OP_CLEAR_ALL;
    logic [IDX_W-1:0] bit_index  = '0;
    logic [LEN_W-1:0] run_length = '0;
    logic             out_valid;
    logic             out_ready  = 1'b0;
    logic             found;
    logic [IDX_W-1:0] run_start;
    logic             bit_value;
    logic             cfg_valid  = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data   = '0;

    // Shadow copy of the map and of the bytes-in-use register
    bit [MAP_BITS-1:0] used_units       = '0;
    logic [CFG_W-1:0]  bytes_in_use_cfg = bra_pkg::CFG_BYTES_RST;

    alloc_result_t pending_results[$];
    int unsigned   mismatch_count = 0;
    int unsigned   items_sent     = 0;
    int unsigned   quiet_cycles   = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;

    bitmap_run_allocator_top #(
        .MAP_BYTES(MAP_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .bit_index (bit_index),
        .run_length(run_length),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .run_start (run_start),
        .bit_value (bit_value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Number of bits a scan covers; register values above the map clamp to it
    function automatic int unsigned scan_limit();
        if (bytes_in_use_cfg > MAP_BYTES)
            return MAP_BITS;
        return bytes_in_use_cfg * 8;
    endfunction

    // Apply one request to the shadow map and return the word it should give
    function automatic alloc_result_t apply_request(input logic [OP_W-1:0] op,
                                                    input logic [IDX_W-1:0] idx,
                                                    input logic [LEN_W-1:0] len);
        alloc_result_t r;
        int unsigned   streak;
        int unsigned   limit;
        r      = '0;
        streak = 0;
        limit  = scan_limit();
        case (op)
            bra_pkg::OP_CLEAR_ALL: used_units = '0;
            bra_pkg::OP_TEST:      if (idx < MAP_BITS) r.bit_value = used_units[idx];
            bra_pkg::OP_SET:       if (idx < MAP_BITS) used_units[idx] = 1'b1;
            bra_pkg::OP_CLEAR:     if (idx < MAP_BITS) used_units[idx] = 1'b0;
            bra_pkg::OP_SCAN:
            begin
                // first fit: lowest run of len free bits inside the window
                if (len != 0)
                begin
                    for (int unsigned i = 0; i < limit && !r.found; i++)
                    begin
                        streak = used_units[i] ? 0 : streak + 1;
                        if (streak == len)
                        begin
                            r.found     = 1'b1;
                            r.run_start = IDX_W'(i + 1 - len);
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [OP_W-1:0] random_opcode();
        case ($urandom_range(0, 19))
            0:                  return bra_pkg::OP_CLEAR_ALL;
            1, 2, 3, 4:         return bra_pkg::OP_TEST;
            5, 6, 7, 8:         return bra_pkg::OP_SET;
            9, 10, 11:          return bra_pkg::OP_CLEAR;
            12, 13, 14, 15, 16: return bra_pkg::OP_SCAN;
            17:                 return OP_UNUSED_5;
            18:                 return OP_UNUSED_6;
            default:            return OP_UNUSED_7;
        endcase
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    // Receiver: out_ready drops at the current stall rate
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare each result word against the oldest expectation
    always @(posedge clk)
    begin : result_check
        alloc_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                note_mismatch($sformatf("result word with none expected (found %0d start %0d bit %0d)",
                                        found, run_start, bit_value));
            else
            begin
                want = pending_results.pop_front();
                if (found !== want.found)
                    note_mismatch($sformatf("found expected %0d, got %0d", want.found, found));
                if (run_start !== want.run_start)
                    note_mismatch($sformatf("run_start expected %0d, got %0d",
                                            want.run_start, run_start));
                if (bit_value !== want.bit_value)
                    note_mismatch($sformatf("bit_value expected %0d, got %0d",
                                            want.bit_value, bit_value));
            end
        end
    end

    // Count cycles in which no channel moves a word
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("tb NOT OK");
        $finish;
    end

    // Send one request word, with a random idle gap ahead of it
    task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [LEN_W-1:0] len, output alloc_result_t predicted);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        bit_index  <= idx;
        run_length <= len;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = apply_request(op, idx, len);
        pending_results.push_back(predicted);
        if (op <= bra_pkg::OP_SCAN)
            items_sent++;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_bytes_in_use(input logic [CFG_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        bytes_in_use_cfg = value;
    endtask

    task automatic set_pace(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Field extremes, every opcode, run-length corner cases over the full map
    task automatic test_bit_ops();
        alloc_result_t r;
        set_pace(0, 0);
        // whole map is one run
        send_word(bra_pkg::OP_SCAN, '0, LEN_W'(MAP_BITS), r);
        send_word(bra_pkg::OP_TEST, '0, '0, r);
        send_word(bra_pkg::OP_SET, '0, '1, r);
        send_word(bra_pkg::OP_SET, '1, '0, r);
        send_word(bra_pkg::OP_TEST, '1, '1, r);
        // fits between the ends
        send_word(bra_pkg::OP_SCAN, '1, LEN_W'(MAP_BITS - 2), r);
        // too long
        send_word(bra_pkg::OP_SCAN, '0, LEN_W'(MAP_BITS - 1), r);
        // longest encodable length
        send_word(bra_pkg::OP_SCAN, '0, '1, r);
        // zero length
        send_word(bra_pkg::OP_SCAN, '1, '0, r);
        send_word(bra_pkg::OP_CLEAR, '0, '0, r);
        send_word(bra_pkg::OP_SCAN, '0, LEN_W'(MAP_BITS - 1), r);
        send_word(OP_UNUSED_5, '1, '1, r);
        send_word(OP_UNUSED_6, '1, '1, r);
        send_word(OP_UNUSED_7, '1, '1, r);
        send_word(bra_pkg::OP_CLEAR_ALL, '1, '1, r);
        send_word(bra_pkg::OP_TEST, '1, '0, r);
    endtask

    // Scan window: full window, bits outside it, empty window, oversized register
    task automatic test_scan_window();
        alloc_result_t r;
        write_bytes_in_use(8'd1);
        send_word(bra_pkg::OP_SET, 10'd1000, '0, r);
        for (int k = 0; k < 8; k++)
            send_word(bra_pkg::OP_SET, IDX_W'(k), '0, r);
        send_word(bra_pkg::OP_SCAN, '0, 11'd1, r);           // window full
        send_word(bra_pkg::OP_TEST, 10'd1000, '0, r);        // outside window still reached
        send_word(bra_pkg::OP_CLEAR_ALL, '0, '0, r);         // clears past the window
        send_word(bra_pkg::OP_TEST, 10'd1000, '0, r);
        write_bytes_in_use(8'd0);
        send_word(bra_pkg::OP_SCAN, '0, 11'd1, r);
        write_bytes_in_use(8'hff);
        send_word(bra_pkg::OP_SCAN, '0, LEN_W'(MAP_BITS), r);
    endtask

    // Allocator-style traffic: scan then claim the run, free runs, probes, noise
    task automatic run_random_phase(input logic [CFG_W-1:0] cfg, input int unsigned count);
        alloc_result_t r;
        alloc_result_t ignored;
        int unsigned   goal;
        int unsigned   limit;
        int unsigned   span;
        int unsigned   len;
        int unsigned   start;
        int unsigned   pick;
        write_bytes_in_use(cfg);
        goal = items_sent + count;
        while (items_sent < goal)
        begin
            pick  = $urandom_range(0, 99);
            limit = scan_limit();
            span  = (limit != 0) ? limit : MAP_BITS;
            if (pick < 40)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                send_word(bra_pkg::OP_SCAN, IDX_W'($urandom_range(0, MAP_BITS - 1)),
                          LEN_W'(len), r);
                if (r.found)
                    for (int k = 0; k < len; k++)
                        send_word(bra_pkg::OP_SET, IDX_W'(r.run_start + k),
                                  LEN_W'($urandom_range(0, 2047)), ignored);
            end
            else if (pick < 60)
            begin
                start = $urandom_range(0, span - 1);
                len   = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    send_word(bra_pkg::OP_CLEAR, IDX_W'(start + k),
                              LEN_W'($urandom_range(0, 2047)), ignored);
            end
            else if (pick < 72)
                send_word(bra_pkg::OP_TEST, IDX_W'($urandom_range(0, span - 1)),
                          LEN_W'($urandom_range(0, 2047)), ignored);
            else if (pick < 85)
            begin
                case ($urandom_range(0, 9))
                    0:             len = $urandom_range(0, 2047);
                    1, 2, 3, 4:    len = $urandom_range(1, limit + 8);
                    default:       len = $urandom_range(1, 16);
                endcase
                send_word(bra_pkg::OP_SCAN, IDX_W'($urandom_range(0, MAP_BITS - 1)),
                          LEN_W'(len), ignored);
            end
            else if (pick < 98)
                send_word(random_opcode(), IDX_W'($urandom_range(0, MAP_BITS - 1)),
                          LEN_W'($urandom_range(0, 2047)), ignored);
            else
                send_word(bra_pkg::OP_CLEAR_ALL, IDX_W'($urandom_range(0, MAP_BITS - 1)),
                          LEN_W'($urandom_range(0, 2047)), ignored);
        end
    endtask

    // Phases rotate through pacing modes and register settings
    task automatic test_random_traffic();
        logic [CFG_W-1:0] cfg_plan [PHASES] = '{8'd128, 8'd16, 8'd255, 8'd1, 8'd64, 8'd0,
                                                 8'd129, 8'd4, 8'd128, 8'd32, 8'd2, 8'd127};
        logic [CFG_W-1:0] cfg;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0:       set_pace(0, 0);
                1:       set_pace(51, 0);
                2:       set_pace(0, 51);
                default: set_pace(10, 10);
            endcase
            cfg = (p == 7) ? CFG_W'($urandom_range(2, 127)) : cfg_plan[p];
            run_random_phase(cfg, RANDOM_ITEMS / PHASES);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_bit_ops();
        test_scan_window();
        test_random_traffic();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
